// ===== hdl/cell_reference_parser_top_assert.svh =====
// Assertion macros shared by the checker of the cell reference parser.
// Each macro states one clocked property that is ignored while reset is active.
`ifndef CELL_REFERENCE_PARSER_TOP_ASSERT_SVH
`define CELL_REFERENCE_PARSER_TOP_ASSERT_SVH

// Same-cycle implication.
`define CRP_ASSERT_NOW(lbl, clock, resetn, ante, cons) \
    lbl: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error("cell reference parser check failed");

// Next-cycle implication.
`define CRP_ASSERT_NEXT(lbl, clock, resetn, ante, cons) \
    lbl: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error("cell reference parser check failed");

`endif

// ===== hdl/crp_pkg.sv =====
// ----------------------------------------------------------------------------
// crp_pkg
// Types, constants and character helpers of the cell reference parser.
// ----------------------------------------------------------------------------
package crp_pkg;

    localparam int ChW     = 8;
    localparam int ColW    = 16;
    localparam int RowW    = 24;
    localparam int RowAccW = 25;
    localparam int MaxRowW = 25;

    localparam logic [RowAccW-1:0] RowSat       = '1;
    localparam logic [MaxRowW-1:0] RowLimit     = 25'd16777216;
    localparam logic [MaxRowW-1:0] MaxRowsReset = 25'd1048576;

    localparam logic [ChW-1:0] CharDollar = 8'h24;
    localparam logic [ChW-1:0] CharZero   = 8'h30;
    localparam logic [ChW-1:0] CharNine   = 8'h39;
    localparam logic [ChW-1:0] CharUpperA = 8'h41;
    localparam logic [ChW-1:0] CharUpperZ = 8'h5A;
    localparam logic [ChW-1:0] CharLowerA = 8'h61;
    localparam logic [ChW-1:0] CharLowerZ = 8'h7A;
    localparam logic [ChW-1:0] CaseMask   = 8'hDF;

    typedef enum logic [2:0]
    {
        PhStart   = 3'd0,
        PhDollar1 = 3'd1,
        PhLetters = 3'd2,
        PhDollar2 = 3'd3,
        PhDigits  = 3'd4,
        PhDone    = 3'd5
    } phase_t;

    typedef struct packed
    {
        phase_t               phase;
        logic [ColW-1:0]      col_accum;
        logic [RowAccW-1:0]   row_accum;
        logic                 failed;
    } parse_state_t;

    typedef struct packed
    {
        logic            ok;
        logic [RowW-1:0] row;
        logic [ColW-1:0] col;
    } parse_result_t;

    function automatic logic is_letter(input logic [ChW-1:0] c);
        return (c >= CharUpperA && c <= CharUpperZ) || (c >= CharLowerA && c <= CharLowerZ);
    endfunction

    function automatic logic is_digit(input logic [ChW-1:0] c);
        return c >= CharZero && c <= CharNine;
    endfunction

endpackage

// ===== hdl/crp_step.sv =====
// ----------------------------------------------------------------------------
// crp_step
// Parser state update and result formation for one character.
// ----------------------------------------------------------------------------
module crp_step
    import crp_pkg::*;
(
    input  parse_state_t         st,
    input  logic [ChW-1:0]       ch,
    input  logic                 last,
    input  logic [MaxRowW-1:0]   max_rows,
    output parse_state_t         st_next,
    output parse_result_t        res
);

    logic                 letter;
    logic                 digit;
    logic [ChW-1:0]       upper;
    logic [ColW-1:0]      letter_val;
    logic [ColW-1:0]      col_added;
    logic [3:0]           digit_val;
    logic [RowAccW+3:0]   row_wide;
    logic [RowAccW-1:0]   row_added;
    logic [MaxRowW-1:0]   limit;
    parse_state_t         upd;

    always_comb
    begin
        letter     = is_letter(ch);
        digit      = is_digit(ch);
        upper      = ch & CaseMask;
        letter_val = ColW'(upper - CharUpperA + 8'd1);
        col_added  = (st.col_accum << 4) + (st.col_accum << 3) + (st.col_accum << 1)
                     + letter_val;
        digit_val  = 4'(ch - CharZero);
        row_wide   = ({4'd0, st.row_accum} << 3) + ({4'd0, st.row_accum} << 1)
                     + (RowAccW+4)'(digit_val);
        row_added  = (row_wide > (RowAccW+4)'(RowSat)) ? RowSat : row_wide[RowAccW-1:0];

        upd = st;
        if (!st.failed)
        begin
            case (st.phase)
                PhStart:
                begin
                    if (ch == CharDollar)
                    begin
                        upd.phase = PhDollar1;
                    end
                    else if (letter)
                    begin
                        upd.col_accum = col_added;
                        upd.phase     = PhLetters;
                    end
                    else
                    begin
                        upd.failed = 1'b1;
                    end
                end
                PhDollar1:
                begin
                    if (letter)
                    begin
                        upd.col_accum = col_added;
                        upd.phase     = PhLetters;
                    end
                    else
                    begin
                        upd.failed = 1'b1;
                    end
                end
                PhLetters:
                begin
                    if (letter)
                    begin
                        upd.col_accum = col_added;
                    end
                    else if (ch == CharDollar)
                    begin
                        upd.phase = PhDollar2;
                    end
                    else if (digit)
                    begin
                        upd.row_accum = row_added;
                        upd.phase     = PhDigits;
                    end
                    else
                    begin
                        upd.failed = 1'b1;
                    end
                end
                PhDollar2:
                begin
                    if (digit)
                    begin
                        upd.row_accum = row_added;
                        upd.phase     = PhDigits;
                    end
                    else
                    begin
                        upd.failed = 1'b1;
                    end
                end
                PhDigits:
                begin
                    if (digit)
                    begin
                        upd.row_accum = row_added;
                    end
                    else
                    begin
                        upd.phase = PhDone;
                    end
                end
                default:
                begin
                    upd = st;
                end
            endcase
        end

        limit  = (max_rows > RowLimit) ? RowLimit : max_rows;
        res.ok = !upd.failed && (upd.phase == PhDigits || upd.phase == PhDone)
                 && (upd.row_accum != '0) && (upd.row_accum <= limit);
        res.row = res.ok ? RowW'(upd.row_accum - 25'd1) : '0;
        res.col = res.ok ? (upd.col_accum - 16'd1) : '0;

        if (last)
        begin
            st_next = '{phase: PhStart, col_accum: '0, row_accum: '0, failed: 1'b0};
        end
        else
        begin
            st_next = upd;
        end
    end

endmodule

// ===== hdl/cell_reference_parser_top.sv =====
// ----------------------------------------------------------------------------
// cell_reference_parser_top
// Streaming parser of A1-style spreadsheet cell references.
// ----------------------------------------------------------------------------
// The slave stream carries one character per beat in s_axis_tdata, with
// s_axis_tlast on the final character of a reference. On that final beat the
// block emits one result beat on the master stream: m_axis_tuser is the valid
// flag, m_axis_tdata holds the zero-based row and column. Other beats give no
// result. An invalid result carries zero row and column.
// A beat is captured in an input register and parsed from there; on a final
// beat the parse result is written into the result register, which presents
// the result beat. One beat is taken every cycle as long as the result
// register can drain; the single character stage between the two registers
// sets that rate.
// When the receiver stalls, the result register holds its beat and the input
// register keeps taking non-final characters; a final character waits in the
// input register until the result register is free.
// Reset empties both registers, clears the parse state and sets max_rows to
// 1048576. cfg_wdata is written to max_rows whenever cfg_wen is high, which
// is allowed only while the block is idle.
// ----------------------------------------------------------------------------
module cell_reference_parser_top
    import crp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wen,
    input  logic [MaxRowW-1:0]  cfg_wdata,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [7:0]          s_axis_tdata,   // [7:0] ch
    input  logic                s_axis_tlast,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [39:0]         m_axis_tdata,   // [23:0] row, [39:24] col
    output logic                m_axis_tuser    // [0] valid_res
);

    logic                in_valid_reg;
    logic [ChW-1:0]      in_ch_reg;
    logic                in_last_reg;
    logic                out_valid_reg;
    parse_result_t       out_res_reg;
    parse_state_t        st_reg;
    parse_state_t        st_next;
    parse_result_t       res;
    logic [MaxRowW-1:0]  max_rows_reg;
    logic                out_free;
    logic                in_adv;
    logic                in_take;

    crp_step u_step
    (
        .st       (st_reg),
        .ch       (in_ch_reg),
        .last     (in_last_reg),
        .max_rows (max_rows_reg),
        .st_next  (st_next),
        .res      (res)
    );

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign in_adv        = in_valid_reg && (!in_last_reg || out_free);
    assign s_axis_tready = !in_valid_reg || in_adv;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            st_reg        <= '{phase: PhStart, col_accum: '0, row_accum: '0, failed: 1'b0};
            max_rows_reg  <= MaxRowsReset;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (in_adv)
            begin
                in_valid_reg <= 1'b0;
            end

            if (in_adv)
            begin
                st_reg <= st_next;
            end

            if (in_adv && in_last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_wen)
            begin
                max_rows_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_ch_reg   <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
        if (in_adv && in_last_reg)
        begin
            out_res_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_res_reg.ok;
    assign m_axis_tdata  = {out_res_reg.col, out_res_reg.row};

endmodule

// ===== hdl/crp_checker.sv =====
// ----------------------------------------------------------------------------
// crp_checker
// Port-level checks of the cell reference parser, bound to the top level.
// ----------------------------------------------------------------------------
`include "cell_reference_parser_top_assert.svh"

module crp_checker
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wen,
    input  logic [24:0]  cfg_wdata,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,
    input  logic         s_axis_tlast,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [39:0]  m_axis_tdata,
    input  logic         m_axis_tuser
);

    // A stalled result beat must hold its contents.
    `CRP_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // An invalid result carries zero row and column.
    `CRP_ASSERT_NOW(a_invalid_zero, clk, rst_n, m_axis_tvalid && !m_axis_tuser,
        m_axis_tdata == 40'd0)

    // With room in the result register the input side is never blocked.
    `CRP_ASSERT_NOW(a_ready_free, clk, rst_n, !m_axis_tvalid || m_axis_tready,
        s_axis_tready)

endmodule

bind cell_reference_parser_top crp_checker u_crp_checker (.*);

// ===== tb/cell_reference_checker.sv =====
// ----------------------------------------------------------------------------
// cell_reference_checker
// Watches the character and result streams of the cell reference parser,
// keeps its own parse of every reference and compares each result beat
// field by field with the oldest predicted result.
// ----------------------------------------------------------------------------
module cell_reference_checker
    import crp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wen,
    input  logic [MaxRowW-1:0] cfg_wdata,
    input  logic               s_axis_tvalid,
    input  logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,   // [7:0] ch
    input  logic               s_axis_tlast,
    input  logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    input  logic [39:0]        m_axis_tdata,   // [23:0] row, [39:24] col
    input  logic               m_axis_tuser,   // [0] valid_res
    output int                 errors,
    output int                 pending,
    output int                 results_checked,
    output int                 valid_results
);
    timeunit 1ns;
    timeprecision 1ps;

    parse_state_t       parse_now;
    logic [MaxRowW-1:0] max_rows;
    parse_result_t      expected_refs[$];

    function automatic logic letter_char(input logic [ChW-1:0] c);
        return (c >= CharUpperA && c <= CharUpperZ) || (c >= CharLowerA && c <= CharLowerZ);
    endfunction

    function automatic logic digit_char(input logic [ChW-1:0] c);
        return c >= CharZero && c <= CharNine;
    endfunction

    function automatic logic [ColW-1:0] add_letter(input logic [ColW-1:0] col,
                                                   input logic [ChW-1:0] c);
        logic [ChW-1:0] upper;
        upper = (c >= CharLowerA) ? c - 8'd32 : c;
        return col * 16'd26 + {8'd0, upper - CharUpperA + 8'd1};
    endfunction

    function automatic logic [RowAccW-1:0] add_digit(input logic [RowAccW-1:0] row,
                                                     input logic [ChW-1:0] c);
        logic [63:0] grown;
        grown = 64'(row) * 64'd10 + 64'(c - CharZero);
        return (grown > 64'(RowSat)) ? RowSat : grown[RowAccW-1:0];
    endfunction

    function automatic parse_state_t scan_char(input parse_state_t st, input logic [ChW-1:0] c);
        parse_state_t nx;
        nx = st;
        if (st.failed)
            return nx;
        case (st.phase)
            PhStart:
                if (c == CharDollar)
                    nx.phase = PhDollar1;
                else if (letter_char(c))
                begin
                    nx.col_accum = add_letter(st.col_accum, c);
                    nx.phase = PhLetters;
                end
                else
                    nx.failed = 1'b1;
            PhDollar1:
                if (letter_char(c))
                begin
                    nx.col_accum = add_letter(st.col_accum, c);
                    nx.phase = PhLetters;
                end
                else
                    nx.failed = 1'b1;
            PhLetters:
                if (letter_char(c))
                    nx.col_accum = add_letter(st.col_accum, c);
                else if (c == CharDollar)
                    nx.phase = PhDollar2;
                else if (digit_char(c))
                begin
                    nx.row_accum = add_digit(st.row_accum, c);
                    nx.phase = PhDigits;
                end
                else
                    nx.failed = 1'b1;
            PhDollar2:
                if (digit_char(c))
                begin
                    nx.row_accum = add_digit(st.row_accum, c);
                    nx.phase = PhDigits;
                end
                else
                    nx.failed = 1'b1;
            PhDigits:
                if (digit_char(c))
                    nx.row_accum = add_digit(st.row_accum, c);
                else
                    nx.phase = PhDone;
            default:
                nx = st;
        endcase
        return nx;
    endfunction

    function automatic parse_result_t close_ref(input parse_state_t st,
                                                input logic [MaxRowW-1:0] rows);
        parse_result_t      res;
        logic [MaxRowW-1:0] limit;
        logic [RowAccW-1:0] row_less;
        logic [ColW-1:0]    col_less;
        limit = (rows > RowLimit) ? RowLimit : rows;
        row_less = st.row_accum - 25'd1;
        col_less = st.col_accum - 16'd1;
        res.ok = !st.failed && (st.phase == PhDigits || st.phase == PhDone) &&
                 st.row_accum >= 25'd1 && st.row_accum <= limit;
        res.row = res.ok ? row_less[RowW-1:0] : '0;
        res.col = res.ok ? col_less : '0;
        return res;
    endfunction

    task automatic report(input string what, input longint got, input longint want);
        $display("MISMATCH at %0t: %s, got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        parse_result_t want;
        if (!rst_n)
        begin
            parse_now = '0;
            max_rows = MaxRowsReset;
            expected_refs.delete();
            errors = 0;
            results_checked = 0;
            valid_results = 0;
            pending <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_checked++;
                if (m_axis_tuser)
                    valid_results++;
                if (expected_refs.size() == 0)
                    report("result beat with nothing expected", m_axis_tdata, 0);
                else
                begin
                    want = expected_refs.pop_front();
                    if (m_axis_tuser !== want.ok)
                        report("valid_res", m_axis_tuser, want.ok);
                    if (m_axis_tdata[23:0] !== want.row)
                        report("row", m_axis_tdata[23:0], want.row);
                    if (m_axis_tdata[39:24] !== want.col)
                        report("col", m_axis_tdata[39:24], want.col);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                parse_now = scan_char(parse_now, s_axis_tdata);
                if (s_axis_tlast)
                begin
                    expected_refs.push_back(close_ref(parse_now, max_rows));
                    parse_now = '0;
                end
            end
            if (cfg_wen)
                max_rows = cfg_wdata;
            pending <= expected_refs.size();
        end
    end

endmodule

// ===== tb/cell_reference_parser_top_tb.sv =====
// ----------------------------------------------------------------------------
// cell_reference_parser_top_tb
// Feeds the cell reference parser with directed and random references under
// several max_rows settings, with random gaps on both streams, and leaves
// prediction and comparison to the checker beside it.
// ----------------------------------------------------------------------------
module cell_reference_parser_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import crp_pkg::*;

    localparam int IdleLimit   = 2000;
    localparam int DrainCycles = 10;
    localparam int CharTarget  = 2000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_wen;
    logic [MaxRowW-1:0] cfg_wdata;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [7:0]         s_axis_tdata;   // [7:0] ch
    logic               s_axis_tlast;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [39:0]        m_axis_tdata;   // [23:0] row, [39:24] col
    logic               m_axis_tuser;   // [0] valid_res

    int      errors;
    int      pending;
    int      results_checked;
    int      valid_results;
    int      chars_sent = 0;
    int      refs_sent = 0;
    int      idle_cycles = 0;
    bit      steady = 1'b0;
    longint  max_rows_now = 1048576;
    logic [7:0] cell_text[$];

    longint  row_settings[8] = '{1048576, 1, 0, 16777216, 33554431, 999, -1, 1048576};

    always #2 clk = ~clk;

    cell_reference_parser_top uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wen       (cfg_wen),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    cell_reference_checker checker_i
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wen         (cfg_wen),
        .cfg_wdata       (cfg_wdata),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tlast    (s_axis_tlast),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tuser    (m_axis_tuser),
        .errors          (errors),
        .pending         (pending),
        .results_checked (results_checked),
        .valid_results   (valid_results)
    );

    function automatic int draw_pause();
        if (steady || $urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(0, 17);
    endfunction

    task automatic send_char(input logic [7:0] c, input logic fin);
        int gap;
        gap = draw_pause();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= fin;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        chars_sent++;
        if (fin)
            refs_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], i == s.len() - 1);
    endtask

    task automatic send_cell();
        for (int i = 0; i < cell_text.size(); i++)
            send_char(cell_text[i], i == cell_text.size() - 1);
    endtask

    task automatic push_number(input longint n);
        string s;
        s = $sformatf("%0d", n);
        for (int i = 0; i < s.len(); i++)
            cell_text.push_back(s[i]);
    endtask

    task automatic build_cell();
        int     kind;
        int     pick;
        longint limit;
        longint rowval;
        kind = $urandom_range(0, 99);
        cell_text.delete();
        if (kind < 12)
        begin
            repeat ($urandom_range(1, 6))
                cell_text.push_back(8'($urandom_range(0, 255)));
            return;
        end
        if ($urandom_range(0, 1))
            cell_text.push_back(CharDollar);
        pick = $urandom_range(0, 9);
        repeat ((pick < 7) ? $urandom_range(1, 2) : (pick < 9) ? 3 : $urandom_range(4, 6))
            cell_text.push_back(($urandom_range(0, 1) ? CharLowerA : CharUpperA) +
                                8'($urandom_range(0, 25)));
        if ($urandom_range(0, 1))
            cell_text.push_back(CharDollar);
        if ($urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 2))
                cell_text.push_back(CharZero);
        limit = (max_rows_now > 16777216) ? 16777216 : max_rows_now;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            rowval = 0;
        else if (pick < 3)
            rowval = limit - 1 + $urandom_range(0, 2);
        else if (pick == 3)
            rowval = longint'($urandom) * 1000 + $urandom_range(0, 999);
        else if (pick < 8)
            rowval = $urandom_range(1, 999);
        else
            rowval = $urandom_range(1, 16777216);
        if (rowval < 0)
            rowval = 0;
        push_number(rowval);
        pick = $urandom_range(0, 5);
        if (pick < 2)
        begin
            cell_text.push_back((pick == 0) ? 8'h00 : 8'($urandom_range(0, 255)));
            repeat ($urandom_range(0, 3))
                cell_text.push_back(8'($urandom_range(0, 255)));
        end
        if (kind < 30)
            cell_text[$urandom_range(0, cell_text.size() - 1)] = 8'($urandom_range(0, 255));
    endtask

    task automatic write_max_rows(input longint value);
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= value[MaxRowW-1:0];
        @(posedge clk);
        cfg_wen   <= 1'b0;
        max_rows_now = value;
    endtask

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            cfg_wen)
            idle_cycles <= 0;
        else if (idle_cycles >= IdleLimit)
        begin
            $display("Timeout: no beat moved for %0d cycles", IdleLimit);
            $display("Verification failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin : receiver
        int stall;
        m_axis_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            stall = draw_pause();
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
        end
    end

    initial
    begin : stimulus
        int phase_end;
        cfg_wen       <= 1'b0;
        cfg_wdata     <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_text("A1");
        send_text("$z$9");
        send_char(8'h00, 1'b1);
        send_text("B0");
        send_char("C", 1'b0);
        send_char("5", 1'b0);
        send_char(8'h00, 1'b0);
        send_char("Q", 1'b1);
        send_char("D", 1'b0);
        send_char("7", 1'b0);
        send_char(8'hFF, 1'b1);
        send_text("$$1");
        send_text("A");
        send_text("XFD1048576");

        foreach (row_settings[i])
        begin
            if (i > 0)
                write_max_rows((row_settings[i] < 0) ? longint'($urandom_range(1, 16777216))
                                                     : row_settings[i]);
            steady = (i % 3 == 1);
            phase_end = chars_sent + CharTarget / $size(row_settings);
            while (chars_sent < phase_end)
            begin
                build_cell();
                send_cell();
            end
        end

        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
        $display("Sent %0d characters in %0d references under %0d max_rows settings.",
                 chars_sent, refs_sent, $size(row_settings));
        $display("Checked %0d result beats, %0d of them valid references.",
                 results_checked, valid_results);
        if (errors == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
